### hw/rtl/integer_literal_parser_assert.svh
// assertion macros for the integer literal parser checks
// used by ilp_checker.sv, no other dependencies
`ifndef INTEGER_LITERAL_PARSER_ASSERT_SVH
`define INTEGER_LITERAL_PARSER_ASSERT_SVH

// same-cycle implication, off while reset is high
`define ILP_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("integer literal parser check failed");

// next-cycle implication, off while reset is high
`define ILP_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("integer literal parser check failed");

`endif

### hw/rtl/ilp_pkg.sv
`timescale 1ns / 1ps
// shared types, codes and character constants of the integer literal parser
// no dependencies
package ilp_pkg;

   localparam int VALUE_WIDTH_DEFAULT = 32;
   localparam int OUT_VALUE_WIDTH     = 32;
   localparam int CHAR_WIDTH          = 8;

   localparam logic [CHAR_WIDTH-1:0] CH_NUL     = 8'h00;
   localparam logic [CHAR_WIDTH-1:0] CH_NEWLINE = 8'h0A;
   localparam logic [CHAR_WIDTH-1:0] CH_TAB     = 8'h09;
   localparam logic [CHAR_WIDTH-1:0] CH_SPACE   = 8'h20;
   localparam logic [CHAR_WIDTH-1:0] CH_DIGIT_0 = 8'h30;
   localparam logic [CHAR_WIDTH-1:0] CH_DIGIT_9 = 8'h39;
   localparam logic [CHAR_WIDTH-1:0] CH_UPPER_A = 8'h41;
   localparam logic [CHAR_WIDTH-1:0] CH_UPPER_F = 8'h46;
   localparam logic [CHAR_WIDTH-1:0] CH_LOWER_A = 8'h61;
   localparam logic [CHAR_WIDTH-1:0] CH_LOWER_F = 8'h66;
   localparam logic [CHAR_WIDTH-1:0] CH_UPPER_X = 8'h58;
   localparam logic [CHAR_WIDTH-1:0] CH_LOWER_X = 8'h78;

   typedef enum logic [2:0] {
      PH_IDLE,
      PH_LEAD,
      PH_ZERO,
      PH_DIGIT,
      PH_TRAIL
   } phase_type;

   typedef enum logic [1:0] {
      RADIX_8,
      RADIX_10,
      RADIX_16
   } radix_type;

   typedef enum logic [1:0] {
      ST_OK,
      ST_MISSING,
      ST_ILLEGAL
   } status_type;

   typedef struct packed {
      logic       blank;
      logic       term;
      logic       zero;
      logic       hex_x;
      logic       is_digit;
      logic [3:0] digit;
   } char_class_type;

   typedef struct packed {
      logic [OUT_VALUE_WIDTH-1:0] value;
      status_type                 status;
      logic [CHAR_WIDTH-1:0]      stop_char;
   } result_type;

endpackage

### hw/rtl/ilp_if.sv
`timescale 1ns / 1ps
// valid/ready channel interfaces for the integer literal parser
// depends on ilp_pkg
interface ilp_req_if;
   import ilp_pkg::*;

   logic                  valid;
   logic                  ready;
   logic [CHAR_WIDTH-1:0] ch;
   logic                  first;

   modport source (output valid, output ch, output first, input ready);
   modport sink (input valid, input ch, input first, output ready);
   modport monitor (input valid, input ch, input first, input ready);
endinterface

interface ilp_rsp_if;
   import ilp_pkg::*;

   logic                       valid;
   logic                       ready;
   logic [OUT_VALUE_WIDTH-1:0] value;
   logic [1:0]                 status;
   logic [CHAR_WIDTH-1:0]      stop_char;

   modport source (output valid, output value, output status, output stop_char, input ready);
   modport sink (input valid, input value, input status, input stop_char, output ready);
   modport monitor (input valid, input value, input status, input stop_char, input ready);
endinterface

### hw/rtl/ilp_classify.sv
`timescale 1ns / 1ps
// character classifier: blanks, terminators, prefix characters, hex digit value
// depends on ilp_pkg
module ilp_classify (
   input  logic [ilp_pkg::CHAR_WIDTH-1:0] ch,
   output ilp_pkg::char_class_type        cls
);
   import ilp_pkg::*;

   logic is_dec;
   logic is_hex_letter;

   always_comb begin
      is_dec        = (ch >= CH_DIGIT_0) && (ch <= CH_DIGIT_9);
      is_hex_letter = ((ch >= CH_UPPER_A) && (ch <= CH_UPPER_F)) ||
                      ((ch >= CH_LOWER_A) && (ch <= CH_LOWER_F));
      cls.blank     = (ch == CH_SPACE) || (ch == CH_TAB);
      cls.term      = (ch == CH_NUL) || (ch == CH_NEWLINE);
      cls.zero      = (ch == CH_DIGIT_0);
      cls.hex_x     = (ch == CH_LOWER_X) || (ch == CH_UPPER_X);
      cls.is_digit  = is_dec || is_hex_letter;
      // letters a-f / A-F have low nibble 1..6, so add 9
      cls.digit     = is_hex_letter ? (ch[3:0] + 4'd9) : ch[3:0];
   end

endmodule

### hw/rtl/ilp_core.sv
`timescale 1ns / 1ps
// parse state machine: phase, radix and accumulator, one character per step
// depends on ilp_pkg
module ilp_core #(
   parameter int VALUE_WIDTH = ilp_pkg::VALUE_WIDTH_DEFAULT
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           step,
   input  logic                           first,
   input  logic [ilp_pkg::CHAR_WIDTH-1:0] ch,
   input  ilp_pkg::char_class_type        cls,
   output logic                           emit,
   output ilp_pkg::result_type            result
);
   import ilp_pkg::*;

   phase_type              phase_ff, phase_in;
   radix_type              radix_ff, radix_in;
   logic [VALUE_WIDTH-1:0] accum_ff, accum_in;

   phase_type              eff_phase;
   radix_type              eff_radix;
   radix_type              use_radix;
   logic [VALUE_WIDTH-1:0] eff_accum;
   logic [VALUE_WIDTH-1:0] scaled;
   logic [VALUE_WIDTH-1:0] mac;
   logic [VALUE_WIDTH+OUT_VALUE_WIDTH-1:0] accum_wide;
   logic                   digit_path;
   logic                   trail_path;
   logic                   too_big;
   logic                   take_digit;
   logic                   missing;

   // first restarts the parse before the character is looked at
   always_comb begin
      eff_phase  = first ? PH_LEAD : phase_ff;
      eff_radix  = first ? RADIX_10 : radix_ff;
      eff_accum  = first ? '0 : accum_ff;

      use_radix  = eff_radix;
      digit_path = 1'b0;
      unique case (eff_phase)
         PH_LEAD: begin
            use_radix  = RADIX_10;
            digit_path = !cls.blank && !cls.term && !cls.zero;
         end
         PH_ZERO: begin
            use_radix  = cls.term ? RADIX_10 : RADIX_8;
            digit_path = !cls.hex_x;
         end
         PH_DIGIT: begin
            digit_path = 1'b1;
         end
         default: begin
         end
      endcase

      unique case (use_radix)
         RADIX_8:  too_big = cls.digit[3];
         RADIX_10: too_big = (cls.digit >= 4'd10);
         default:  too_big = 1'b0;
      endcase

      unique case (use_radix)
         RADIX_8:  scaled = eff_accum << 3;
         RADIX_10: scaled = (eff_accum << 3) + (eff_accum << 1);
         default:  scaled = eff_accum << 4;
      endcase
      mac = scaled + VALUE_WIDTH'(cls.digit);

      take_digit = digit_path && cls.is_digit && !too_big;
      trail_path = (eff_phase == PH_TRAIL) || (digit_path && !cls.is_digit);
      missing    = (eff_phase == PH_LEAD) && cls.term;
   end

   // next phase
   always_comb begin
      phase_in = phase_ff;
      if (step) begin
         priority if (eff_phase == PH_IDLE) begin
            phase_in = PH_IDLE;
         end else if (missing) begin
            phase_in = PH_IDLE;
         end else if ((eff_phase == PH_LEAD) && cls.blank) begin
            phase_in = PH_LEAD;
         end else if ((eff_phase == PH_LEAD) && cls.zero) begin
            phase_in = PH_ZERO;
         end else if ((eff_phase == PH_ZERO) && cls.hex_x) begin
            phase_in = PH_DIGIT;
         end else if (digit_path && cls.is_digit) begin
            phase_in = too_big ? PH_IDLE : PH_DIGIT;
         end else begin
            phase_in = cls.blank ? PH_TRAIL : PH_IDLE;
         end
      end
   end

   // datapath and result
   always_comb begin
      radix_in = radix_ff;
      accum_in = accum_ff;
      if (step) begin
         radix_in = ((eff_phase == PH_ZERO) && cls.hex_x) ? RADIX_16 : use_radix;
         accum_in = take_digit ? mac : eff_accum;
      end

      emit = step && (missing || (digit_path && cls.is_digit && too_big) ||
                      (trail_path && !cls.blank));

      accum_wide = {OUT_VALUE_WIDTH'(0), eff_accum};
      result.stop_char = ch;
      priority if (missing) begin
         result.status = ST_MISSING;
         result.value  = '0;
      end else if (digit_path && cls.is_digit) begin
         result.status = ST_ILLEGAL;
         result.value  = '0;
      end else begin
         result.status = ST_OK;
         result.value  = accum_wide[OUT_VALUE_WIDTH-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         radix_ff <= RADIX_10;
         accum_ff <= '0;
      end else begin
         phase_ff <= phase_in;
         radix_ff <= radix_in;
         accum_ff <= accum_in;
      end
   end

endmodule

### hw/rtl/integer_literal_parser.sv
`timescale 1ns / 1ps
// integer literal parser top level: input register, parse core, result register
// depends on ilp_pkg, ilp_if, ilp_classify, ilp_core
//
//   channel    dir   payload                         role
//   req_chan   in    ch[7:0], first                  one character per item
//   rsp_chan   out   value[31:0], status, stop_char  one item per parse, number or error
//
// one character item accepted per cycle, sustained, while rsp_chan drains
// rsp valid follows the accepting req edge through the input reg, then the result reg
// the path between the two registers is classify + one shift-add by 8, 10 or 16
// synchronous reset clears control state, the parse phase, radix and accumulator
// a stalled result holds the parse; req_ready drops only when both registers are full
// and rsp_ready is low
module integer_literal_parser #(
   parameter int VALUE_WIDTH = ilp_pkg::VALUE_WIDTH_DEFAULT
) (
   input logic       clock,
   input logic       reset,
   ilp_req_if.sink   req_chan,
   ilp_rsp_if.source rsp_chan
);
   import ilp_pkg::*;

   // input register
   logic                  in_valid_ff, in_valid_in;
   logic [CHAR_WIDTH-1:0] in_ch_ff;
   logic                  in_first_ff;

   // result register
   logic                  out_valid_ff, out_valid_in;
   result_type            out_result_ff;

   logic                  advance;
   logic                  accept;
   logic                  emit;
   char_class_type        cls;
   result_type            result;

   // the held character moves into the core when the result slot is free or draining
   assign advance = in_valid_ff && (!out_valid_ff || rsp_chan.ready);
   assign accept  = req_chan.valid && req_chan.ready;

   assign req_chan.ready = !in_valid_ff || advance;

   ilp_classify u_classify (
      .ch  (in_ch_ff),
      .cls (cls)
   );

   ilp_core #(
      .VALUE_WIDTH (VALUE_WIDTH)
   ) u_core (
      .clock  (clock),
      .reset  (reset),
      .step   (advance),
      .first  (in_first_ff),
      .ch     (in_ch_ff),
      .cls    (cls),
      .emit   (emit),
      .result (result)
   );

   always_comb begin
      in_valid_in = in_valid_ff;
      if (accept) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end

      out_valid_in = out_valid_ff;
      if (advance) begin
         out_valid_in = emit;
      end else if (rsp_chan.ready) begin
         out_valid_in = 1'b0;
      end
   end

   // control
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // payload, no reset
   always_ff @(posedge clock) begin
      if (accept) begin
         in_ch_ff    <= req_chan.ch;
         in_first_ff <= req_chan.first;
      end
      if (advance && emit) begin
         out_result_ff <= result;
      end
   end

   assign rsp_chan.valid     = out_valid_ff;
   assign rsp_chan.value     = out_result_ff.value;
   assign rsp_chan.status    = out_result_ff.status;
   assign rsp_chan.stop_char = out_result_ff.stop_char;

endmodule

### hw/rtl/ilp_checker.sv
`timescale 1ns / 1ps
// port-level checks on the integer literal parser, bound to the top level
// depends on ilp_pkg, ilp_if, integer_literal_parser_assert.svh
`include "integer_literal_parser_assert.svh"

module ilp_checker (
   input logic       clock,
   input logic       reset,
   ilp_req_if.sink   req_chan,
   ilp_rsp_if.source rsp_chan
);
   import ilp_pkg::*;

   logic rsp_blank_stop;
   logic rsp_error;
   logic rsp_end_stop;

   assign rsp_blank_stop = (rsp_chan.stop_char == CH_SPACE) || (rsp_chan.stop_char == CH_TAB);
   assign rsp_error      = (rsp_chan.status == ST_MISSING) || (rsp_chan.status == ST_ILLEGAL);
   assign rsp_end_stop   = (rsp_chan.stop_char == CH_NUL) ||
                           (rsp_chan.stop_char == CH_NEWLINE);

   // a blank never ends a number
   `ILP_ASSERT_NOW(a_stop_not_blank, clock, reset, rsp_chan.valid, !rsp_blank_stop)
   // errors carry a zero value
   `ILP_ASSERT_NOW(a_error_value_zero, clock, reset, rsp_chan.valid && rsp_error,
                   rsp_chan.value == '0)
   // missing number only at a terminator
   `ILP_ASSERT_NOW(a_missing_at_end, clock, reset,
                   rsp_chan.valid && (rsp_chan.status == ST_MISSING), rsp_end_stop)
   // nothing comes out in the cycle after reset
   `ILP_ASSERT_NOW(a_quiet_after_reset, clock, reset, $past(reset), !rsp_chan.valid)
   // a result that is not taken stays up
   `ILP_ASSERT_NEXT(a_rsp_held, clock, reset, rsp_chan.valid && !rsp_chan.ready,
                    rsp_chan.valid)

endmodule

bind integer_literal_parser ilp_checker u_ilp_checker (
   .clock    (clock),
   .reset    (reset),
   .req_chan (req_chan),
   .rsp_chan (rsp_chan)
);
